[rtl/core/ilid_pkg.sv]
// shared types and constants for the indexed list block
`default_nettype none

package ilid_pkg;

    // fixed field widths of the request and result
    localparam int OP_W     = 2;
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 7;

    // operation codes
    typedef logic [OP_W-1:0] t_op;
    localparam t_op OP_APPEND = 2'd0;
    localparam t_op OP_INSERT = 2'd1;
    localparam t_op OP_DELETE = 2'd2;
    localparam t_op OP_READ   = 2'd3;

    // status codes
    typedef logic [STATUS_W-1:0] t_status;
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

endpackage

`default_nettype wire

[rtl/core/indexed_list_insert_delete.sv]
// indexed list with append, insert, delete and read at an index
// a rejected request goes straight to the finish state, append writes in the insert read state,
// read waits in S_RWAIT for the ram, and insert and delete walk the entries between index p and count
// each moved entry takes a ram read state and a ram write state on the shared stepper
// one request in flight; the next is taken in the cycle after the result loads
// reset: synchronous active low, clears the count and the control state only
`default_nettype none

module indexed_list_insert_delete #(
    parameter int CAPACITY      = 64,
    parameter int ELEMENT_WIDTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // request channel
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [ilid_pkg::OP_W-1:0]      i_operation,
    input  wire logic [ilid_pkg::POS_W-1:0]     i_position,
    input  wire logic [ilid_pkg::VAL_W-1:0]     i_value_in,
    // result channel
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic      [ilid_pkg::VAL_W-1:0]     o_value_out,
    output logic      [ilid_pkg::STATUS_W-1:0]  o_status,
    output logic      [ilid_pkg::COUNT_W-1:0]   o_element_count,
    output logic                                o_is_empty
);

    import ilid_pkg::*;

    localparam int AW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_IRD,
        S_IWR,
        S_DRD,
        S_DWR,
        S_RWAIT,
        S_FIN
    } t_state;

    t_state                   r_state;
    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_idx;
    logic [CW-1:0]            r_pos;
    logic [ELEMENT_WIDTH-1:0] r_val;
    logic [ELEMENT_WIDTH-1:0] r_rd;
    t_status                  r_res_status;

    logic                     r_out_valid;
    logic [VAL_W-1:0]         r_value_out;
    t_status                  r_status;
    logic [COUNT_W-1:0]       r_out_count;
    logic                     r_out_empty;

    logic                     in_acc;
    logic                     out_load;
    logic [CMPW-1:0]          pos_ext;
    logic [CMPW-1:0]          cnt_ext;
    logic                     is_full;
    logic [CW-1:0]            idx_step;

    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [ELEMENT_WIDTH-1:0] ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [ELEMENT_WIDTH-1:0] ram_rdata;

    // handshake and range checks
    assign o_stall  = (r_state != S_IDLE);
    assign in_acc   = i_valid && !o_stall;
    assign out_load = (r_state == S_FIN) && (!r_out_valid || !i_stall);
    assign pos_ext  = CMPW'(i_position);
    assign cnt_ext  = CMPW'(r_count);
    assign is_full  = (r_count >= CW'(CAPACITY));

    // shared index stepper: up for delete, down for insert
    assign idx_step = (r_state == S_DRD || r_state == S_DWR) ? (r_idx + 1'b1)
                                                             : (r_idx - 1'b1);

    // ram port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = AW'(r_idx);
        ram_wdata = ram_rdata;
        ram_raddr = AW'(idx_step);
        case (r_state)
            S_IDLE: begin
                ram_raddr = AW'(i_position);
            end
            S_IRD: begin
                if (r_idx == r_pos) begin
                    ram_we    = 1'b1;
                    ram_wdata = r_val;
                end
            end
            S_IWR: begin
                ram_we = 1'b1;
            end
            S_DWR: begin
                ram_we = 1'b1;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    ilid_ram #(
        .WIDTH (ELEMENT_WIDTH),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // sequencer, count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // result register fills on load and empties when taken
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_val        <= ELEMENT_WIDTH'(i_value_in);
                        r_rd         <= '0;
                        r_res_status <= ST_OK;
                        case (i_operation)
                            OP_APPEND: begin
                                if (is_full) begin
                                    r_res_status <= ST_FULL;
                                    r_state      <= S_FIN;
                                end else begin
                                    r_pos   <= r_count;
                                    r_idx   <= r_count;
                                    r_state <= S_IRD;
                                end
                            end
                            OP_INSERT: begin
                                if (pos_ext > cnt_ext) begin
                                    r_res_status <= ST_RANGE;
                                    r_state      <= S_FIN;
                                end else if (is_full) begin
                                    r_res_status <= ST_FULL;
                                    r_state      <= S_FIN;
                                end else begin
                                    r_pos   <= CW'(i_position);
                                    r_idx   <= r_count;
                                    r_state <= S_IRD;
                                end
                            end
                            OP_DELETE: begin
                                if (pos_ext >= cnt_ext) begin
                                    r_res_status <= ST_RANGE;
                                    r_state      <= S_FIN;
                                end else begin
                                    r_pos   <= CW'(i_position);
                                    r_idx   <= CW'(i_position);
                                    r_state <= S_DRD;
                                end
                            end
                            default: begin
                                if (pos_ext >= cnt_ext) begin
                                    r_res_status <= ST_RANGE;
                                    r_state      <= S_FIN;
                                end else begin
                                    r_state <= S_RWAIT;
                                end
                            end
                        endcase
                    end
                end
                // move entries up, then drop the new value in place
                S_IRD: begin
                    if (r_idx == r_pos) begin
                        r_count <= r_count + 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_IWR;
                    end
                end
                S_IWR: begin
                    r_idx   <= idx_step;
                    r_state <= S_IRD;
                end
                // move entries down over the deleted one
                S_DRD: begin
                    if (idx_step == r_count) begin
                        r_count <= r_count - 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DWR;
                    end
                end
                S_DWR: begin
                    r_idx   <= idx_step;
                    r_state <= S_DRD;
                end
                S_RWAIT: begin
                    r_rd    <= ram_rdata;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_load) begin
                        r_value_out <= VAL_W'(r_rd);
                        r_status    <= r_res_status;
                        r_out_count <= COUNT_W'(r_count);
                        r_out_empty <= (r_count == '0);
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid         = r_out_valid;
    assign o_value_out     = r_value_out;
    assign o_status        = r_status;
    assign o_element_count = r_out_count;
    assign o_is_empty      = r_out_empty;

    // count never exceeds capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("count above capacity");

    // count moves only at the end of an append, insert or delete
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IRD && r_state != S_DRD) |=> r_count == $past(r_count))
        else $error("count changed outside insert or delete");

    // insert walk stays between target index and count
    a_ins_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IRD || r_state == S_IWR) |-> (r_idx >= r_pos && r_idx <= r_count))
        else $error("insert index out of walk range");

    // delete walk stays between target index and last entry
    a_del_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DRD || r_state == S_DWR) |-> (r_idx >= r_pos && r_idx < r_count))
        else $error("delete index out of walk range");

    // a rejected request leaves the read value at zero
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_res_status != ST_OK) |=> o_value_out == '0)
        else $error("nonzero value on rejected request");

endmodule

`default_nettype wire

[rtl/core/ilid_ram.sv]
// generic single write port ram with registered read
`default_nettype none

module ilid_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

[verif/tb_indexed_list_insert_delete.sv]
// self-checking testbench for the indexed list block with a shadow list scoreboard
`timescale 1ns / 100ps

module tb_indexed_list_insert_delete;

    import ilid_pkg::*;

    localparam int LIST_CAP     = 64;
    localparam int PHASE_ITEMS  = 350;
    localparam int SEGMENT_LEN  = 120;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;

    // one expected or observed result
    typedef struct packed {
        logic [VAL_W-1:0]   value;
        t_status            status;
        logic [COUNT_W-1:0] count;
        logic               empty;
    } t_list_result;

    // shadow copy of the list and the queue of results it predicts
    class t_list_tracker;
        logic [VAL_W-1:0] contents [LIST_CAP];
        int unsigned      held;
        t_list_result     pending [$];
        int               errors;

        function new();
            held   = 0;
            errors = 0;
        endfunction

        // apply one accepted request to the shadow list and queue its result
        function void accept_request(t_op op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
            t_list_result res;
            int unsigned  p;
            int           i;
            p          = pos;
            res.value  = '0;
            res.status = ST_OK;
            case (op)
                OP_APPEND: begin
                    if (held >= LIST_CAP) begin
                        res.status = ST_FULL;
                    end else begin
                        contents[held] = val;
                        held++;
                    end
                end
                OP_INSERT: begin
                    // index check comes before the full check
                    if (p > held) begin
                        res.status = ST_RANGE;
                    end else if (held >= LIST_CAP) begin
                        res.status = ST_FULL;
                    end else begin
                        for (i = held; i > p; i--) begin
                            contents[i] = contents[i-1];
                        end
                        contents[p] = val;
                        held++;
                    end
                end
                OP_DELETE: begin
                    if (p >= held) begin
                        res.status = ST_RANGE;
                    end else begin
                        for (i = p; i + 1 < held; i++) begin
                            contents[i] = contents[i+1];
                        end
                        held--;
                    end
                end
                default: begin
                    if (p >= held) begin
                        res.status = ST_RANGE;
                    end else begin
                        res.value = contents[p];
                    end
                end
            endcase
            res.count = COUNT_W'(held);
            res.empty = (held == 0);
            pending.push_back(res);
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_result(t_list_result got);
            t_list_result exp;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) begin
                    $display("unexpected result: value %h status %0d count %0d empty %0d",
                             got.value, got.status, got.count, got.empty);
                end
            end else begin
                exp = pending.pop_front();
                if (exp.value !== got.value || exp.status !== got.status ||
                    exp.count !== got.count || exp.empty !== got.empty) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("mismatch: exp value %h status %0d count %0d empty %0d",
                                 exp.value, exp.status, exp.count, exp.empty);
                        $display("          got value %h status %0d count %0d empty %0d",
                                 got.value, got.status, got.count, got.empty);
                    end
                end
            end
        endfunction
    endclass

    logic               i_clk           = 1'b0;
    logic               i_rst_n         = 1'b0;
    logic               i_valid         = 1'b0;
    logic               o_stall;
    logic [OP_W-1:0]    i_operation     = OP_APPEND;
    logic [POS_W-1:0]   i_position      = '0;
    logic [VAL_W-1:0]   i_value_in      = '0;
    logic               o_valid;
    logic               i_stall         = 1'b0;
    logic [VAL_W-1:0]   o_value_out;
    logic [STATUS_W-1:0] o_status;
    logic [COUNT_W-1:0] o_element_count;
    logic               o_is_empty;

    int                 send_idle_pct   = 0;
    int                 stall_pct       = 0;
    int                 hold_left       = 0;
    t_list_tracker      tracker         = new();

    indexed_list_insert_delete u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_operation     (i_operation),
        .i_position      (i_position),
        .i_value_in      (i_value_in),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_value_out     (o_value_out),
        .o_status        (o_status),
        .o_element_count (o_element_count),
        .o_is_empty      (o_is_empty)
    );

    // clock
    always #5 i_clk = ~i_clk;

    // receiver: long hold-off when asked, otherwise random stalls
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_stall   <= 1'b1;
            hold_left <= hold_left - 1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // check results first, then record the request taken at the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                tracker.check_result('{o_value_out, o_status, o_element_count, o_is_empty});
            end
            if (i_valid && !o_stall) begin
                tracker.accept_request(t_op'(i_operation), i_position, i_value_in);
            end
        end
    end

    // offer one request, with random idle cycles ahead of it, until it is taken
    task automatic send_request(input t_op op, input int pos, input logic [VAL_W-1:0] val);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_operation <= op;
        i_position  <= POS_W'(pos);
        i_value_in  <= val;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    // random request biased to grow, churn or shrink the list
    task automatic send_random(input int mode);
        int               roll;
        int               pos;
        int unsigned      n;
        t_op              op;
        logic [VAL_W-1:0] val;
        n    = tracker.held;
        roll = $urandom_range(99);
        case (mode)
            0:       op = roll < 40 ? OP_APPEND : roll < 80 ? OP_INSERT :
                          roll < 90 ? OP_DELETE : OP_READ;
            1:       op = roll < 25 ? OP_APPEND : roll < 50 ? OP_INSERT :
                          roll < 75 ? OP_DELETE : OP_READ;
            default: op = roll < 10 ? OP_APPEND : roll < 20 ? OP_INSERT :
                          roll < 70 ? OP_DELETE : OP_READ;
        endcase
        // mostly legal positions, some anywhere from 0 to 64
        if ($urandom_range(99) < 12) begin
            pos = $urandom_range(64);
        end else if (op == OP_INSERT) begin
            pos = $urandom_range(n);
        end else if (op == OP_APPEND) begin
            pos = $urandom_range(64);
        end else begin
            pos = (n == 0) ? 0 : $urandom_range(n - 1);
        end
        roll = $urandom_range(9);
        val  = (roll == 0) ? '0 : (roll == 1) ? '1 : VAL_W'($urandom);
        send_request(op, pos, val);
    endtask

    // run limit
    initial begin
        #10_000_000;
        $display("tb_indexed_list_insert_delete failed");
        $finish;
    end

    // main sequence
    initial begin
        int phase;
        int k;
        int n;
        int idle_tab [5];
        int stall_tab [5];
        idle_tab  = '{0, 75, 0, 21, 0};
        stall_tab = '{0, 0, 75, 21, 0};

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty list, edges of the index range, extreme values
        send_request(OP_READ,   0,  32'h0);
        send_request(OP_DELETE, 0,  32'h0);
        send_request(OP_INSERT, 1,  32'h1234_5678);
        send_request(OP_INSERT, 0,  32'hFFFF_FFFF);
        send_request(OP_APPEND, 0,  32'h0000_0000);
        send_request(OP_APPEND, 64, 32'hA5A5_5A5A);
        send_request(OP_INSERT, 3,  32'h0000_0001);
        send_request(OP_INSERT, 5,  32'hDEAD_BEEF);
        send_request(OP_INSERT, 2,  32'h8000_0000);
        send_request(OP_READ,   0,  32'h0);
        send_request(OP_READ,   4,  32'h0);
        send_request(OP_READ,   5,  32'h0);
        send_request(OP_READ,   64, 32'hFFFF_FFFF);
        send_request(OP_DELETE, 4,  32'h0);
        send_request(OP_DELETE, 0,  32'h0);
        send_request(OP_DELETE, 64, 32'h0);
        send_request(OP_DELETE, 3,  32'h0);
        send_request(OP_READ,   1,  32'h0);
        send_request(OP_APPEND, 0,  32'h7FFF_FFFF);
        send_request(OP_READ,   3,  32'h0);

        // random phases with different idle and stall mixes
        n = 0;
        for (phase = 0; phase < 5; phase++) begin
            send_idle_pct = idle_tab[phase];
            stall_pct     = stall_tab[phase];
            if (phase == 4) begin
                // receiver holds off while requests keep coming
                @(posedge i_clk);
                hold_left = HOLD_CYCLES;
                @(negedge i_clk);
            end
            for (k = 0; k < PHASE_ITEMS; k++) begin
                send_random((n / SEGMENT_LEN) % 3);
                n++;
            end
        end
        i_valid       <= 1'b0;
        send_idle_pct = 0;
        stall_pct     = 0;

        // drain
        while (tracker.pending.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (tracker.errors == 0) begin
            $display("tb_indexed_list_insert_delete passed");
        end else begin
            $display("tb_indexed_list_insert_delete failed");
        end
        $finish;
    end

endmodule
